### design/csp_pkg.sv
// csp_pkg: shared types, codes and the fixed color-name table for the
// color specification parser. No dependencies; used by csp_name_match and
// color_spec_parser.
`timescale 1ns / 1ps

package csp_pkg;

   // Table geometry
   localparam int NAME_COUNT = 14;
   localparam int MASK_W     = 15;
   localparam int NAME_CHARS = 10;
   localparam int TEXT_W     = NAME_CHARS * 8;
   localparam int LEN_W      = 4;
   localparam int STORE_W    = 48;
   localparam int COUNT_W    = 4;

   // Parse modes
   localparam logic [1:0] MODE_START = 2'd0;
   localparam logic [1:0] MODE_HEX   = 2'd1;
   localparam logic [1:0] MODE_NAME  = 2'd2;

   // Accepted hex digit counts
   localparam logic [COUNT_W-1:0] DIGITS_SHORT = 4'd3;
   localparam logic [COUNT_W-1:0] DIGITS_BYTE  = 4'd6;
   localparam logic [COUNT_W-1:0] DIGITS_FULL  = 4'd12;

   localparam logic [7:0] CHAR_HASH = 8'h23;

   // Result of a name lookup: hit flag and the high bytes of red, green, blue
   typedef struct packed {
      logic        found;
      logic [23:0] rgb;
   } name_hit_type;

   typedef struct packed {
      logic       valid;
      logic [3:0] value;
   } hex_digit_type;

   // Name text, first character in the lowest byte (strings are written reversed)
   localparam logic [TEXT_W-1:0] NAME_TEXT [NAME_COUNT] = '{
      TEXT_W'("kcalb"),
      TEXT_W'("etihw"),
      TEXT_W'("der"),
      TEXT_W'("neerg"),
      TEXT_W'("eulb"),
      TEXT_W'("wolley"),
      TEXT_W'("nayc"),
      TEXT_W'("atnegam"),
      TEXT_W'("yarg"),
      TEXT_W'("yerg"),
      TEXT_W'("yarg thgil"),
      TEXT_W'("yerg thgil"),
      TEXT_W'("yarg krad"),
      TEXT_W'("yerg krad")
   };

   localparam logic [LEN_W-1:0] NAME_LEN [NAME_COUNT] = '{
      4'd5, 4'd5, 4'd3, 4'd5, 4'd4, 4'd6, 4'd4, 4'd7,
      4'd4, 4'd4, 4'd10, 4'd10, 4'd9, 4'd9
   };

   // High bytes of red, green, blue, red most significant
   localparam logic [23:0] NAME_RGB [NAME_COUNT] = '{
      24'h000000, 24'hffffff, 24'hff0000, 24'h00ff00,
      24'h0000ff, 24'hffff00, 24'h00ffff, 24'hff00ff,
      24'h808080, 24'h808080, 24'hd3d3d3, 24'hd3d3d3,
      24'ha9a9a9, 24'ha9a9a9
   };

   // Decode one ASCII hex digit in either case
   function automatic hex_digit_type hex_digit(input logic [7:0] c);
      hex_digit_type d;
      d.valid = 1'b1;
      d.value = 4'd0;
      if (c inside {[8'h30:8'h39]}) begin
         d.value = c[3:0];
      end else if (c inside {[8'h41:8'h46], [8'h61:8'h66]}) begin
         d.value = c[3:0] + 4'd9;
      end else begin
         d.valid = 1'b0;
      end
      return d;
   endfunction

endpackage

### design/csp_name_match.sv
// csp_name_match: candidate mask and length update for name mode, plus the
// table lookup on the updated mask and length. Depends on csp_pkg.
`timescale 1ns / 1ps

module csp_name_match (
   input  logic                     take_char,
   input  logic [7:0]               char_code,
   input  logic [14:0]              cur_mask,
   input  logic [3:0]               cur_length,
   output logic [14:0]              next_mask,
   output logic [3:0]               next_length,
   output csp_pkg::name_hit_type    hit
);
   import csp_pkg::*;

   logic [7:0]        lower;
   logic [TEXT_W-1:0] text_shift;

   // Lowercase and narrow the candidate set by one position
   always_comb begin
      lower       = char_code;
      next_mask   = cur_mask;
      next_length = cur_length;
      text_shift  = '0;
      if (char_code inside {[8'h41:8'h5A]}) begin
         lower = char_code + 8'd32;
      end
      if (take_char) begin
         for (int i = 0; i < NAME_COUNT; i++) begin
            text_shift = NAME_TEXT[i] >> {cur_length, 3'd0};
            if (cur_length >= NAME_LEN[i] || text_shift[7:0] != lower) begin
               next_mask[i] = 1'b0;
            end
         end
         // spare entry never matches
         next_mask[MASK_W-1] = 1'b0;
         if (cur_length != 4'hf) begin
            next_length = cur_length + 4'd1;
         end
      end
   end

   // Pick the first surviving entry whose length matches
   always_comb begin
      hit = '0;
      for (int i = NAME_COUNT - 1; i >= 0; i--) begin
         if (next_mask[i] && NAME_LEN[i] == next_length) begin
            hit.found = 1'b1;
            hit.rgb   = NAME_RGB[i];
         end
      end
   end

endmodule

### design/color_spec_parser.sv
// color_spec_parser: one character per cycle, held only by the wait described below;
// the last item passes through the input register, then the result register.
// Throughput is one item per clock but for that wait; the parse state update and the
// table lookup sit between those two registers. An item that carries last waits in
// the input register only while the result register holds an untaken result.
// Synchronous active-high reset empties both registers and clears the parse state.
`timescale 1ns / 1ps

module color_spec_parser (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] char_code
   input  logic [0:0]  req_tuser,   // [0] no_char
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [71:0] rsp_tdata,   // [15:0] red, [31:16] green, [47:32] blue, [71:48] pixel
   output logic [0:0]  rsp_tuser    // [0] found
);
   import csp_pkg::*;

   // Input register
   logic                 in_valid_ff;
   logic [7:0]           in_char_ff;
   logic                 in_none_ff;
   logic                 in_last_ff;

   // Parse state
   logic [1:0]           mode_ff, mode_in;
   logic [STORE_W-1:0]   store_ff, store_in;
   logic [COUNT_W-1:0]   count_ff, count_in;
   logic                 bad_ff, bad_in;
   logic [MASK_W-1:0]    mask_ff, mask_in;
   logic [LEN_W-1:0]     length_ff, length_in;

   // Result register
   logic                 rsp_valid_ff;
   logic                 rsp_found_ff, rsp_found_in;
   logic [23:0]          rsp_rgb_ff, rsp_rgb_in;

   logic                 req_fire;
   logic                 step;
   logic                 name_take;
   logic                 hex_ok;
   logic [23:0]          hex_rgb;
   hex_digit_type        digit;
   name_hit_type         hit;

   // Advance the input register unless a last item would overwrite a pending result
   assign step       = in_valid_ff && (!in_last_ff || !rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || step;
   assign req_fire   = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_fire) begin
         in_valid_ff <= 1'b1;
      end else if (step) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_char_ff <= req_tdata;
         in_none_ff <= req_tuser[0];
         in_last_ff <= req_tlast;
      end
   end

   // Mode selection and hex digit collection
   always_comb begin
      digit     = hex_digit(in_char_ff);
      mode_in   = mode_ff;
      store_in  = store_ff;
      count_in  = count_ff;
      bad_in    = bad_ff;
      name_take = 1'b0;
      if (!in_none_ff) begin
         case (mode_ff)
            MODE_START: begin
               if (in_char_ff == CHAR_HASH) begin
                  mode_in = MODE_HEX;
               end else begin
                  mode_in   = MODE_NAME;
                  name_take = 1'b1;
               end
            end
            MODE_HEX: begin
               if (!digit.valid || count_ff >= DIGITS_FULL) begin
                  bad_in = 1'b1;
               end else begin
                  store_in = {store_ff[STORE_W-5:0], digit.value};
                  count_in = count_ff + 4'd1;
               end
            end
            MODE_NAME: begin
               name_take = 1'b1;
            end
            default: begin
               mode_in = mode_ff;
            end
         endcase
      end
   end

   csp_name_match u_name_match (
      .take_char   (name_take),
      .char_code   (in_char_ff),
      .cur_mask    (mask_ff),
      .cur_length  (length_ff),
      .next_mask   (mask_in),
      .next_length (length_in),
      .hit         (hit)
   );

   // Extract the high byte of each channel from the digit groups
   always_comb begin
      hex_ok  = (mode_in == MODE_HEX) && !bad_in;
      hex_rgb = '0;
      case (count_in)
         DIGITS_SHORT: begin
            hex_rgb = {store_in[11:8], store_in[11:8], store_in[7:4], store_in[7:4],
                       store_in[3:0], store_in[3:0]};
         end
         DIGITS_BYTE: begin
            hex_rgb = store_in[23:0];
         end
         DIGITS_FULL: begin
            hex_rgb = {store_in[47:40], store_in[31:24], store_in[15:8]};
         end
         default: begin
            hex_ok = 1'b0;
         end
      endcase
   end

   always_comb begin
      rsp_found_in = 1'b0;
      rsp_rgb_in   = '0;
      if (hex_ok) begin
         rsp_found_in = 1'b1;
         rsp_rgb_in   = hex_rgb;
      end else if (mode_in == MODE_NAME && hit.found) begin
         rsp_found_in = 1'b1;
         rsp_rgb_in   = hit.rgb;
      end
   end

   // Update the parse state; a last item returns it to the start
   always_ff @(posedge clock) begin
      if (reset || (step && in_last_ff)) begin
         mode_ff   <= MODE_START;
         store_ff  <= '0;
         count_ff  <= '0;
         bad_ff    <= 1'b0;
         mask_ff   <= '1;
         length_ff <= '0;
      end else if (step) begin
         mode_ff   <= mode_in;
         store_ff  <= store_in;
         count_ff  <= count_in;
         bad_ff    <= bad_in;
         mask_ff   <= mask_in;
         length_ff <= length_in;
      end
   end

   // Hold the result until taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (step && in_last_ff) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (step && in_last_ff) begin
         rsp_found_ff <= rsp_found_in;
         rsp_rgb_ff   <= rsp_rgb_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_found_ff;
   assign rsp_tdata  = {rsp_rgb_ff,
                        rsp_rgb_ff[7:0],   rsp_rgb_ff[7:0],
                        rsp_rgb_ff[15:8],  rsp_rgb_ff[15:8],
                        rsp_rgb_ff[23:16], rsp_rgb_ff[23:16]};

   // Digit count never passes twelve
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= DIGITS_FULL)
      else $error("hex digit count above twelve");

   // Start mode means nothing has been collected
   a_start_clean: assert property (@(posedge clock) disable iff (reset)
      mode_ff == MODE_START |-> (count_ff == '0 && length_ff == '0 && !bad_ff))
      else $error("parse state dirty in start mode");

   // Name mode has always dropped the spare table entry
   a_spare_dropped: assert property (@(posedge clock) disable iff (reset)
      mode_ff == MODE_NAME |-> !mask_ff[MASK_W-1])
      else $error("spare table entry still a candidate");

   // A consumed last item leaves a result and a fresh parse state
   a_last_result: assert property (@(posedge clock) disable iff (reset)
      step && in_last_ff |=> rsp_valid_ff && mode_ff == MODE_START)
      else $error("last item did not produce a result");

   // A failed parse carries a zero color
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_found_ff |-> rsp_rgb_ff == '0)
      else $error("nonzero color on a failed parse");

endmodule

### bench/tb_color_spec_parser.sv
// tb_color_spec_parser: self-checking bench for the color specification parser.
// Streams directed and random color specs, predicts each result and compares it.
// Depends on csp_pkg and color_spec_parser.
`timescale 1ns / 1ps

module tb_color_spec_parser;
   import csp_pkg::*;

   localparam int CYCLE_LIMIT  = 300000;
   localparam int RANDOM_ITEMS = 1500;
   localparam int DRAIN_CYCLES = 12;
   localparam int STYLE_CYCLES = 150;

   typedef struct packed {
      logic [7:0] code;
      logic       no_char;
      logic       last;
   } spec_item_type;

   typedef struct packed {
      logic        found;
      logic [15:0] red;
      logic [15:0] green;
      logic [15:0] blue;
      logic [23:0] pixel;
   } color_result_type;

   // Known color names and the high bytes of red, green, blue
   string color_names [NAME_COUNT] = '{
      "black", "white", "red", "green", "blue", "yellow", "cyan", "magenta",
      "gray", "grey", "light gray", "light grey", "dark gray", "dark grey"
   };
   logic [23:0] color_bytes [NAME_COUNT] = '{
      24'h000000, 24'hffffff, 24'hff0000, 24'h00ff00, 24'h0000ff, 24'hffff00,
      24'h00ffff, 24'hff00ff, 24'h808080, 24'h808080, 24'hd3d3d3, 24'hd3d3d3,
      24'ha9a9a9, 24'ha9a9a9
   };

   string directed_specs [25] = '{
      "black", "WHITE", "Red", "green", "blue", "YeLLow", "cyan", "magenta",
      "gray", "grey", "Light Gray", "light grey", "dark gray", "DARK GREY",
      "#fFf", "#0a1B2c", "#0123456789aB", "#000", "#FFFFFFFFFFFF", "#",
      "#0123456789abc", "#12g", "light greyish blue", "blu", "blacks"
   };

   logic        clock;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata  = 8'h00;   // [7:0] char_code
   logic [0:0]  req_tuser  = 1'b0;    // [0] no_char
   logic        req_tlast  = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [71:0] rsp_tdata;            // [15:0] red, [31:16] green, [47:32] blue, [71:48] pixel
   logic [0:0]  rsp_tuser;            // [0] found

   spec_item_type    pending_items [$];
   color_result_type expected_colors [$];
   logic [7:0]       spec_bytes [$];
   spec_item_type    next_item;

   // Predictor state
   logic [1:0]  scan_mode;
   logic [47:0] hex_nibbles;
   int          hex_count;
   logic        hex_error;
   logic [14:0] name_cands;
   int          name_len;

   int  error_count  = 0;
   int  result_count = 0;
   int  cycle_count  = 0;
   bit  req_taken    = 1'b0;
   int  burst_left   = 1;
   int  gap_left     = 0;
   int  stall_left   = 0;
   int  stall_style  = 0;
   int  style_age    = 0;

   color_spec_parser dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Hold reset at the start, then release it for good
   initial begin
      repeat (10) @(negedge clock);
      reset <= 1'b0;
   end

   function automatic int hex_nibble(input logic [7:0] c);
      if (c >= "0" && c <= "9") return 32'(c - "0");
      if (c >= "a" && c <= "f") return c - "a" + 10;
      if (c >= "A" && c <= "F") return c - "A" + 10;
      return -1;
   endfunction

   task automatic clear_scan();
      scan_mode   = MODE_START;
      hex_nibbles = '0;
      hex_count   = 0;
      hex_error   = 1'b0;
      name_cands  = '1;
      name_len    = 0;
   endtask

   // Drop every name that disagrees at the current position
   task automatic match_name_char(input logic [7:0] raw);
      logic [7:0] c;
      c = raw;
      if (c >= "A" && c <= "Z") c = c + 8'd32;
      for (int i = 0; i < NAME_COUNT; i++) begin
         if (name_len >= color_names[i].len() || color_names[i][name_len] != c)
            name_cands[i] = 1'b0;
      end
      name_cands[MASK_W-1] = 1'b0;
      if (name_len < 15) name_len++;
   endtask

   // Advance the parse by one item; queue the color it yields on a last item
   task automatic parse_char(input spec_item_type it);
      color_result_type res;
      logic [7:0]       hi [3];
      logic [47:0]      group;
      logic [15:0]      chan;
      int               digit;
      int               w;
      if (!it.no_char) begin
         case (scan_mode)
            MODE_START: begin
               if (it.code == CHAR_HASH) begin
                  scan_mode = MODE_HEX;
               end else begin
                  scan_mode = MODE_NAME;
                  match_name_char(it.code);
               end
            end
            MODE_HEX: begin
               digit = hex_nibble(it.code);
               if (digit < 0 || hex_count >= 12) begin
                  hex_error = 1'b1;
               end else begin
                  hex_nibbles = {hex_nibbles[43:0], 4'(digit)};
                  hex_count++;
               end
            end
            default: match_name_char(it.code);
         endcase
      end
      if (it.last) begin
         res = '0;
         if (scan_mode == MODE_HEX && !hex_error &&
             (hex_count == 3 || hex_count == 6 || hex_count == 12)) begin
            w = hex_count / 3;
            for (int k = 0; k < 3; k++) begin
               group = (hex_nibbles >> (4 * w * (2 - k))) & ((48'd1 << (4 * w)) - 48'd1);
               case (w)
                  1:       chan = group[15:0] * 16'h1111;
                  2:       chan = group[15:0] * 16'h0101;
                  default: chan = group[15:0];
               endcase
               hi[k] = chan[15:8];
            end
            res.found = 1'b1;
         end else if (scan_mode == MODE_NAME) begin
            for (int i = 0; i < NAME_COUNT; i++) begin
               if (!res.found && name_cands[i] && color_names[i].len() == name_len) begin
                  res.found = 1'b1;
                  hi[0] = color_bytes[i][23:16];
                  hi[1] = color_bytes[i][15:8];
                  hi[2] = color_bytes[i][7:0];
               end
            end
         end
         if (res.found) begin
            res.red   = {hi[0], hi[0]};
            res.green = {hi[1], hi[1]};
            res.blue  = {hi[2], hi[2]};
            res.pixel = {hi[0], hi[1], hi[2]};
         end
         expected_colors.push_back(res);
         clear_scan();
      end
   endtask

   task automatic report_mismatch(input string what, input logic [23:0] want,
                                  input logic [23:0] got);
      error_count++;
      $display("result %0d: %s mismatch, expected %h got %h", result_count, what, want, got);
   endtask

   // Turn the collected bytes into items; a noisy spec gets stray no-byte items
   task automatic push_spec(input bit noisy);
      int n;
      bit tail_none;
      n = spec_bytes.size();
      tail_none = (n == 0) || (noisy && $urandom_range(0, 9) == 0);
      for (int i = 0; i < n; i++) begin
         if (noisy && $urandom_range(0, 11) == 0)
            pending_items.push_back('{8'($urandom_range(0, 255)), 1'b1, 1'b0});
         pending_items.push_back('{spec_bytes[i], 1'b0, (i == n - 1) && !tail_none});
      end
      if (tail_none) pending_items.push_back('{8'($urandom_range(0, 255)), 1'b1, 1'b1});
      spec_bytes.delete();
   endtask

   task automatic load_text(input string s);
      for (int i = 0; i < s.len(); i++) spec_bytes.push_back(s[i]);
   endtask

   task automatic load_name(input int idx);
      logic [7:0] c;
      for (int i = 0; i < color_names[idx].len(); i++) begin
         c = color_names[idx][i];
         if (c >= "a" && c <= "z" && $urandom_range(0, 1)) c = c - 8'd32;
         spec_bytes.push_back(c);
      end
   endtask

   task automatic load_hex(input int digits);
      int v;
      spec_bytes.push_back(CHAR_HASH);
      for (int i = 0; i < digits; i++) begin
         v = $urandom_range(0, 15);
         if (v < 10) spec_bytes.push_back(8'("0" + v));
         else if ($urandom_range(0, 1)) spec_bytes.push_back(8'("a" + v - 10));
         else spec_bytes.push_back(8'("A" + v - 10));
      end
   endtask

   // Fill the stimulus, then wait for the last color and report
   initial begin
      int         kind;
      int         n;
      int         directed_total;
      logic [7:0] junk;
      clear_scan();

      foreach (directed_specs[i]) begin
         load_text(directed_specs[i]);
         push_spec(1'b0);
      end
      push_spec(1'b0);                          // empty spec
      spec_bytes.push_back(8'h00);
      push_spec(1'b0);
      spec_bytes.push_back(8'hff);
      push_spec(1'b0);
      pending_items.push_back('{"b", 1'b0, 1'b0});
      pending_items.push_back('{"l", 1'b0, 1'b0});
      pending_items.push_back('{8'h5a, 1'b1, 1'b0});
      pending_items.push_back('{"u", 1'b0, 1'b0});
      pending_items.push_back('{"e", 1'b0, 1'b1});
      load_text("cyan");
      spec_bytes.push_back(8'h00);
      spec_bytes.delete();
      pending_items.push_back('{"c", 1'b0, 1'b0});
      pending_items.push_back('{"y", 1'b0, 1'b0});
      pending_items.push_back('{"a", 1'b0, 1'b0});
      pending_items.push_back('{"n", 1'b0, 1'b0});
      pending_items.push_back('{8'hc3, 1'b1, 1'b1});
      directed_total = pending_items.size();

      while (pending_items.size() < directed_total + RANDOM_ITEMS) begin
         kind = $urandom_range(0, 99);
         if (kind < 35) begin
            load_name($urandom_range(0, NAME_COUNT - 1));
         end else if (kind < 65) begin
            case ($urandom_range(0, 2))
               0:       load_hex(3);
               1:       load_hex(6);
               default: load_hex(12);
            endcase
         end else if (kind < 75) begin
            // broken hex: any digit count from 0 to 15 and maybe a non-hex byte
            n = $urandom_range(0, 15);
            load_hex(n);
            if (n > 0 && $urandom_range(0, 1)) begin
               do junk = 8'($urandom_range(0, 255)); while (hex_nibble(junk) >= 0);
               spec_bytes[$urandom_range(1, n)] = junk;
            end
         end else if (kind < 87) begin
            // near-miss names: truncated, extended, altered or joined
            load_name($urandom_range(0, NAME_COUNT - 1));
            case ($urandom_range(0, 3))
               0: void'(spec_bytes.pop_back());
               1: spec_bytes.push_back($urandom_range(0, 3) == 0 ? 8'h20 :
                                       8'($urandom_range("a", "z")));
               2: spec_bytes[$urandom_range(0, spec_bytes.size() - 1)] =
                     8'($urandom_range(0, 255));
               default: load_name($urandom_range(0, NAME_COUNT - 1));
            endcase
         end else begin
            n = $urandom_range(0, 18);
            for (int i = 0; i < n; i++) spec_bytes.push_back(8'($urandom_range(0, 255)));
         end
         push_spec(1'b1);
      end

      wait (!reset);
      while (pending_items.size() != 0 || req_tvalid) @(posedge clock);
      while (expected_colors.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("tb_color_spec_parser: clean");
      end else begin
         $display("tb_color_spec_parser: errors");
      end
      $finish;
   end

   // Send items in bursts with random gaps; hold an item until it is taken
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (req_tvalid && !req_taken) begin
         // hold
      end else if (gap_left > 0) begin
         req_tvalid <= 1'b0;
         gap_left--;
      end else if (pending_items.size() > 0) begin
         next_item = pending_items.pop_front();
         req_tvalid <= 1'b1;
         req_tdata  <= next_item.code;
         req_tuser  <= next_item.no_char;
         req_tlast  <= next_item.last;
         if (burst_left > 1) begin
            burst_left--;
         end else begin
            burst_left = $urandom_range(1, 40);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         end
      end else begin
         req_tvalid <= 1'b0;
      end
   end

   // Stall the result side; the style changes every so often
   always @(negedge clock) begin
      if (stall_left > 0) begin
         rsp_tready <= 1'b0;
         stall_left--;
      end else begin
         rsp_tready <= 1'b1;
         case (stall_style)
            1: if ($urandom_range(0, 1)) stall_left = $urandom_range(1, 3);
            2: if ($urandom_range(0, 7) == 0) stall_left = $urandom_range(5, 25);
            3: stall_left = 2;
            default: stall_left = 0;
         endcase
      end
      style_age++;
      if (style_age == STYLE_CYCLES) begin
         style_age   = 0;
         stall_style = $urandom_range(0, 3);
      end
   end

   // Sample both handshakes, predict on inputs and check each result
   always @(posedge clock) begin
      color_result_type want;
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb_color_spec_parser: errors");
         $finish;
      end else if (reset) begin
         req_taken = 1'b0;
      end else begin
         req_taken = req_tvalid && req_tready;
         if (req_taken) parse_char('{req_tdata, req_tuser[0], req_tlast});
         if (rsp_tvalid && rsp_tready) begin
            if (expected_colors.size() == 0) begin
               report_mismatch("unexpected result, pixel", 24'h0, rsp_tdata[71:48]);
            end else begin
               want = expected_colors.pop_front();
               if (rsp_tuser[0] !== want.found)
                  report_mismatch("found", 24'(want.found), 24'(rsp_tuser[0]));
               if (rsp_tdata[15:0] !== want.red)
                  report_mismatch("red", 24'(want.red), 24'(rsp_tdata[15:0]));
               if (rsp_tdata[31:16] !== want.green)
                  report_mismatch("green", 24'(want.green), 24'(rsp_tdata[31:16]));
               if (rsp_tdata[47:32] !== want.blue)
                  report_mismatch("blue", 24'(want.blue), 24'(rsp_tdata[47:32]));
               if (rsp_tdata[71:48] !== want.pixel)
                  report_mismatch("pixel", want.pixel, rsp_tdata[71:48]);
            end
            result_count++;
         end
      end
   end

endmodule

### sim.f
design/csp_pkg.sv
design/csp_name_match.sv
design/color_spec_parser.sv
bench/tb_color_spec_parser.sv
